// ----- hdl/ksc_pkg.sv -----
// Shared types and constants for the kappa-sigma clip accumulator.
package ksc_pkg;

  localparam int unsigned StoreDepthDefault = 4096;

  localparam int unsigned MeanW  = 24;
  localparam int unsigned VarW   = 40;
  localparam int unsigned CountW = 16;
  localparam int unsigned EntryW = MeanW + VarW + CountW;

  localparam int unsigned DvdW = 50;
  localparam int unsigned DvsW = 17;

  localparam logic FuncAccum = 1'b0;
  localparam logic FuncRead  = 1'b1;

  localparam logic [1:0] CfgMaxSample = 2'd0;
  localparam logic [1:0] CfgWarmup    = 2'd1;
  localparam logic [1:0] CfgKappa     = 2'd2;

  localparam logic [15:0] MaxSampleReset = 16'd65535;
  localparam logic [7:0]  WarmupReset    = 8'd5;
  localparam logic [7:0]  KappaReset     = 8'd48;

  typedef struct packed {
    logic        func;
    logic [11:0] pixel_index;
    logic [15:0] sample;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] mean_out;
    logic [15:0] frame_count;
  } out_t;

  typedef struct packed {
    logic [15:0] max_sample;
    logic [7:0]  warmup_count;
    logic [7:0]  kappa_q4;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic        in_range;
    logic [11:0] pixel_index;
    logic [15:0] sample;
  } q_item_t;

  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

  function automatic logic [15:0] round_mean(input logic [MeanW-1:0] m);
    logic [MeanW:0] r;
    r = {1'b0, m} + (MeanW+1)'(128);
    return r[MeanW] ? 16'hFFFF : r[MeanW-1:8];
  endfunction

endpackage

// ----- hdl/ksc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ksc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/ksc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module ksc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ksc_pkg::DvdW-1:0]  dividend_i,
  input  logic [ksc_pkg::DvsW-1:0]  divisor_i,
  output logic [ksc_pkg::DvdW-1:0]  quotient_o,
  output logic                      done_o
);

  localparam int unsigned DvdW = ksc_pkg::DvdW;
  localparam int unsigned DvsW = ksc_pkg::DvsW;
  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DvsW:0]   rem_sh;
  logic            qbit;

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DvsW-1:0], dvd_q[DvdW-1]};
    qbit   = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? rem_sh - {1'b0, dvs_q} : rem_sh;
      dvd_d = {dvd_q[DvdW-2:0], qbit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

// ----- hdl/ksc_front.sv -----
// Front end: accept items, check the index range, queue them for the back end.
module ksc_front #(
  parameter int unsigned StoreDepth = ksc_pkg::StoreDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  ksc_pkg::in_t         in_item_i,
  input  ksc_pkg::back_stat_t  stat_i,
  output logic                 item_valid_o,
  output ksc_pkg::q_item_t     item_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = 2;

  ksc_pkg::q_item_t q_mem_q [QDepth];
  ksc_pkg::q_item_t new_item;
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full         = stat_i.clearing || (cnt_q == (PtrW+1)'(QDepth));
  assign do_push      = push && !full;
  assign item_valid_o = cnt_q != '0;
  assign do_pop       = stat_i.take && item_valid_o;
  assign item_o       = q_mem_q[rd_q];

  always_comb begin
    new_item.func        = in_item_i.func;
    new_item.pixel_index = in_item_i.pixel_index;
    new_item.sample      = in_item_i.sample;
    new_item.in_range    = {20'd0, in_item_i.pixel_index} < 32'(StoreDepth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_q] <= new_item;
    end
  end

endmodule

// ----- hdl/ksc_back.sv -----
// Back end: read the stores, test the sample, run the update, hold the result.
module ksc_back #(
  parameter int unsigned StoreDepth = ksc_pkg::StoreDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ksc_pkg::cfg_t        cfg_i,
  input  logic                 item_valid_i,
  input  ksc_pkg::q_item_t     item_i,
  output ksc_pkg::back_stat_t  stat_o,
  output logic                 empty,
  input  logic                 pop,
  output ksc_pkg::out_t        out_item_o
);

  localparam int unsigned AddrW  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned MeanW  = ksc_pkg::MeanW;
  localparam int unsigned VarW   = ksc_pkg::VarW;
  localparam int unsigned CountW = ksc_pkg::CountW;
  localparam int unsigned EntryW = ksc_pkg::EntryW;
  localparam int unsigned DvdW   = ksc_pkg::DvdW;
  localparam int unsigned DvsW   = ksc_pkg::DvsW;

  typedef enum logic [3:0] {
    StClear, StIdle, StRead, StMul, StTest, StDivA, StDivB, StDivM
  } state_e;

  state_e            state_q;
  logic [AddrW-1:0]  clr_q;
  ksc_pkg::q_item_t  item_q;
  logic [MeanW-1:0]  m_q;
  logic [VarW-1:0]   v_q;
  logic [CountW-1:0] n_q;
  logic [MeanW-1:0]  d_q;
  logic [15:0]       k2_q;
  logic [47:0]       d2_q;
  logic [55:0]       kv_q;
  logic [41:0]       num_q;
  logic [48:0]       b_q;
  logic [VarW-1:0]   nv_q;
  ksc_pkg::out_t     res_q;
  logic              res_valid_q;

  logic              take;
  logic              res_set;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  logic              div_start;
  logic [DvdW-1:0]   div_dvd;
  logic [DvdW-1:0]   quot;
  logic              div_done;
  logic [DvsW-1:0]   n1;
  logic [MeanW-1:0]  s24, rd_m;
  logic [VarW-1:0]   rd_v;
  logic [CountW-1:0] rd_n;
  logic              pass;
  logic [48:0]       b_next;
  logic [48:0]       diff;
  logic [40:0]       nv_full;
  logic [MeanW-1:0]  lim, nm;
  logic [CountW-1:0] n_next;

  // Start the next item when no result is held, or while the held result leaves in the same cycle.
  assign take = (state_q == StIdle) && item_valid_i && (!res_valid_q || pop);
  assign stat_o.take     = take;
  assign stat_o.clearing = state_q == StClear;

  assign res_set = (take && !item_i.in_range) ||
                   ((state_q == StRead) && (item_q.func == ksc_pkg::FuncRead)) ||
                   ((state_q == StTest) && !pass) ||
                   ((state_q == StDivM) && div_done);

  assign {rd_m, rd_v, rd_n} = ram_rdata;
  assign n1     = {1'b0, n_q} + DvsW'(1);
  assign s24    = {item_q.sample, 8'd0};
  assign pass   = (n_q <= {8'd0, cfg_i.warmup_count}) || ({8'd0, d2_q} < kv_q);
  assign b_next = {1'b0, v_q, 8'd0} + quot[48:0];
  assign diff   = b_q - quot[48:0];
  assign nv_full = diff[48:8];
  assign lim    = {cfg_i.max_sample, 8'd0};
  assign nm     = (quot > DvdW'(lim)) ? lim : quot[MeanW-1:0];
  assign n_next = (n_q == '1) ? n_q : n_q + CountW'(1);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DvdW'(d2_q);
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    unique case (state_q)
      StClear: ram_we = 1'b1;
      StTest:  div_start = pass;
      StDivA: begin
        div_start = div_done;
        div_dvd   = DvdW'(b_next) + DvdW'(n1) - DvdW'(1);
      end
      StDivB: begin
        div_start = div_done;
        div_dvd   = DvdW'(num_q);
      end
      StDivM: begin
        ram_we    = div_done;
        ram_waddr = AddrW'(item_q.pixel_index);
        ram_wdata = {nm, nv_q, n_next};
      end
      default: ;
    endcase
  end

  ksc_ram #(.Width(EntryW), .Depth(StoreDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (AddrW'(item_i.pixel_index)),
    .rdata_o (ram_rdata)
  );

  ksc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (n1),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == AddrW'(StoreDepth - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (take && item_i.in_range) state_q <= StRead;
        end
        StRead: begin
          if (item_q.func == ksc_pkg::FuncRead) begin
            state_q <= StIdle;
          end else begin
            state_q <= StMul;
          end
        end
        StMul: state_q <= StTest;
        StTest: begin
          if (pass) begin
            state_q <= StDivA;
          end else begin
            state_q <= StIdle;
          end
        end
        StDivA: if (div_done) state_q <= StDivB;
        StDivB: if (div_done) state_q <= StDivM;
        StDivM: begin
          if (div_done) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
      res_q  <= '0;
    end
    if (state_q == StRead) begin
      m_q   <= rd_m;
      v_q   <= rd_v;
      n_q   <= rd_n;
      d_q   <= (rd_m > s24) ? rd_m - s24 : s24 - rd_m;
      k2_q  <= cfg_i.kappa_q4 * cfg_i.kappa_q4;
      res_q <= '{accepted: 1'b0, mean_out: ksc_pkg::round_mean(rd_m), frame_count: rd_n};
    end
    if (state_q == StMul) begin
      d2_q  <= d_q * d_q;
      kv_q  <= k2_q * v_q;
      num_q <= 42'(n_q) * 42'(m_q) + 42'(s24) + 42'(n1[DvsW-1:1]);
    end
    if (state_q == StDivA && div_done) begin
      b_q <= b_next;
    end
    if (state_q == StDivB && div_done) begin
      nv_q <= nv_full[40] ? '1 : nv_full[VarW-1:0];
    end
    if (state_q == StDivM && div_done) begin
      res_q <= '{accepted: 1'b1, mean_out: ksc_pkg::round_mean(nm), frame_count: n_next};
    end
  end

  assign empty      = !res_valid_q;
  assign out_item_o = res_q;

endmodule

// ----- hdl/kappa_sigma_clip_accumulator_unit.sv -----
// Path from the push to the result on the ports: an out-of-range index is answered when taken
// from the queue, a read after the store read, a rejected sample after read, multiply and test,
// an accepted one after three serial divider passes. The back end takes no new item until
// idle again; a held result stalls it, and a 4-entry input queue takes pushes meanwhile.
// Reset: registers return to their defaults and a clearing pass writes zero to all
// STORE_DEPTH entries, one per cycle; full stays high throughout that pass.
module kappa_sigma_clip_accumulator_unit #(
  parameter int unsigned STORE_DEPTH = ksc_pkg::StoreDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input queue side
  input  logic          push,
  output logic          full,
  input  ksc_pkg::in_t  in_item_i,
  // result queue side
  output logic          empty,
  input  logic          pop,
  output ksc_pkg::out_t out_item_o,
  // configuration write channel
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  ksc_pkg::cfg_t       cfg_q;
  ksc_pkg::back_stat_t stat;
  ksc_pkg::q_item_t    item;
  logic                item_valid;

  // Configuration transactions always complete, also during the clearing pass;
  // unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_sample   <= ksc_pkg::MaxSampleReset;
      cfg_q.warmup_count <= ksc_pkg::WarmupReset;
      cfg_q.kappa_q4     <= ksc_pkg::KappaReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ksc_pkg::CfgMaxSample: cfg_q.max_sample   <= cfg_data_i;
        ksc_pkg::CfgWarmup:    cfg_q.warmup_count <= cfg_data_i[7:0];
        ksc_pkg::CfgKappa:     cfg_q.kappa_q4     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify, queue for the back end.
  ksc_front #(.StoreDepth(STORE_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .stat_i       (stat),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Back: store access, clipping test, incremental update, result holding.
  ksc_back #(.StoreDepth(STORE_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .stat_o       (stat),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule
